// ----- src/ctds_pkg.sv -----
// Package for the cumulative threshold day search block.
// Holds the sizes, the item and command types shared by the controller,
// the datapath and the top level. Depends on nothing.
package ctds_pkg;

  localparam int MAX_DAYS = 1024;
  localparam int DAY_W = $clog2(MAX_DAYS + 1);
  localparam int ADDR_W = $clog2(MAX_DAYS);
  localparam int AMT_W = 8;
  localparam int TOT_W = 18;
  localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [0:0] {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [AMT_W-1:0] amount_a;
    logic [AMT_W-1:0] amount_b;
    logic [AMT_W-1:0] amount_c;
    logic [TOT_W-1:0] need_a;
    logic [TOT_W-1:0] need_b;
    logic [TOT_W-1:0] need_c;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [DAY_W-1:0] day_index;
  } out_item_t;

  typedef struct packed {
    logic [TOT_W-1:0] a;
    logic [TOT_W-1:0] b;
    logic [TOT_W-1:0] c;
  } totals_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // append one day to the table
    logic query_start;  // capture needs, open the search range, first read
    logic step;         // narrow the range by the last read, next read
    logic capture;      // move the final answer into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic probe_final;  // the pending read is the last check of the search
  } dp_status_t;

endpackage

// ----- src/cumulative_threshold_day_search.sv -----
// Top level of the cumulative threshold day search block.
// Joins ctds_ctrl and ctds_datapath; depends on ctds_pkg.
//
//   Channel  Signals                          Transfer carries
//   in       in_valid_i, in_ready_o, in_data_i    load (amounts) or query (needs)
//   out      out_valid_o, out_ready_i, out_data_o found flag and day index
//
// A load updates the running totals and the table, and the block stays ready for the
// next item. A query is taken in, then the range 0..days loaded is halved step by step
// (the range holds 1025 days when 1024 are loaded), and a final check decides the
// answer; each step makes a single registered read of the prefix-sum memory.
// Reset clears the running totals, the day count and the output valid flag.
// A result waits in the output register; loads are still taken meanwhile, and
// a following query runs its search and holds its answer until the slot frees.
module cumulative_threshold_day_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ctds_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ctds_pkg::out_item_t out_data_o
);

  ctds_pkg::dp_cmd_t    cmd;
  ctds_pkg::dp_status_t status;

  ctds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_func_i   (in_data_i.func),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  ctds_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.day_index == '0)
    else $error("not-found result carries a nonzero day index");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.day_index <= ctds_pkg::DAY_W'(ctds_pkg::MAX_DAYS))
    else $error("day index beyond the table");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.func == ctds_pkg::FUNC_QUERY |=> !in_ready_o)
    else $error("input taken while a search is running");

  a_capture_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> !out_valid_o || out_ready_i)
    else $error("result written over an untaken result");

endmodule

// ----- src/ctds_datapath.sv -----
// Datapath of the cumulative threshold day search block: running totals,
// the prefix-sum memory, the search range registers and the result register.
// Depends on ctds_pkg.
module ctds_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctds_pkg::in_item_t   in_data_i,
  input  ctds_pkg::dp_cmd_t    cmd_i,
  output ctds_pkg::dp_status_t status_o,
  output ctds_pkg::out_item_t  out_data_o
);

  localparam int DW = ctds_pkg::DAY_W;
  localparam int TW = ctds_pkg::TOT_W;

  // Day d (1..MAX_DAYS) lives at address d-1; day 0 is all zeros.
  ctds_pkg::totals_t mem [ctds_pkg::MAX_DAYS];

  logic [DW-1:0]     days_q, days_d;
  ctds_pkg::totals_t tot_q, tot_d;
  logic              full;

  logic [DW-1:0]     lo_q, lo_d, hi_q, hi_d;
  ctds_pkg::totals_t need_q;
  logic [DW-1:0]     probe_q, probe_d;
  logic              probe_final_q, probe_final_d;
  logic              rd_zero_q;
  ctds_pkg::totals_t rd_data_q;
  logic [ctds_pkg::ADDR_W-1:0] rd_addr;
  logic [DW:0]       mid_sum;
  logic [DW-1:0]     probe_m1;
  ctds_pkg::totals_t cur;
  logic              meets;
  logic              probe_en;

  ctds_pkg::out_item_t out_q;

  function automatic logic [TW-1:0] sat_add(logic [TW-1:0] t,
                                            logic [ctds_pkg::AMT_W-1:0] a);
    logic [TW:0] s;
    s = {1'b0, t} + (TW + 1)'(a);
    return s[TW] ? ctds_pkg::TOTAL_MAX : s[TW-1:0];
  endfunction

  assign full = (days_q == DW'(ctds_pkg::MAX_DAYS));

  always_comb begin
    tot_d.a = sat_add(tot_q.a, in_data_i.amount_a);
    tot_d.b = sat_add(tot_q.b, in_data_i.amount_b);
    tot_d.c = sat_add(tot_q.c, in_data_i.amount_c);
    days_d  = days_q + DW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      days_q <= '0;
      tot_q  <= '0;
    end else if (cmd_i.load && !full) begin
      days_q <= days_d;
      tot_q  <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem[days_q[ctds_pkg::ADDR_W-1:0]] <= tot_d;
    end
  end

  // A day reads as zeros when it is day 0.
  assign cur   = rd_zero_q ? '0 : rd_data_q;
  assign meets = (cur.a >= need_q.a) && (cur.b >= need_q.b) && (cur.c >= need_q.c);

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.query_start) begin
      lo_d = '0;
      hi_d = days_q;
    end else if (cmd_i.step) begin
      if (meets) begin
        hi_d = probe_q;
      end else begin
        lo_d = probe_q + DW'(1);
      end
    end
    mid_sum       = ({1'b0, lo_d} + {1'b0, hi_d}) >> 1;
    probe_final_d = !(lo_d < hi_d);
    probe_d       = probe_final_d ? hi_d : mid_sum[DW-1:0];
    probe_m1      = probe_d - DW'(1);
    rd_addr       = probe_m1[ctds_pkg::ADDR_W-1:0];
  end

  assign probe_en = cmd_i.query_start || cmd_i.step;

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      need_q.a <= in_data_i.need_a;
      need_q.b <= in_data_i.need_b;
      need_q.c <= in_data_i.need_c;
    end
    if (probe_en) begin
      lo_q          <= lo_d;
      hi_q          <= hi_d;
      probe_q       <= probe_d;
      probe_final_q <= probe_final_d;
      rd_zero_q     <= (probe_d == '0);
      rd_data_q     <= mem[rd_addr];
    end
    if (cmd_i.capture) begin
      out_q.found     <= meets;
      out_q.day_index <= meets ? probe_q : '0;
    end
  end

  assign status_o.probe_final = probe_final_q;
  assign out_data_o           = out_q;

endmodule

// ----- src/ctds_ctrl.sv -----
// Controller of the cumulative threshold day search block: input handshake,
// search sequencing and the output valid flag.
// Depends on ctds_pkg.
module ctds_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ctds_pkg::func_e      in_func_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ctds_pkg::dp_cmd_t    cmd_o,
  input  ctds_pkg::dp_status_t status_i
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_func_i == ctds_pkg::FUNC_QUERY) begin
            cmd_o.query_start = 1'b1;
            state_d           = ST_SEARCH;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (!status_i.probe_final) begin
          cmd_o.step = 1'b1;
        end else if (slot_free) begin
          // The last read decides the answer; hold here while the output is full.
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
